[src/sage_pkg.sv]
// ----------------------------------------------------------------------------
// sage_pkg: shared types and constants
// Constants, command and status bundles for the auto gain and exposure block.
// ----------------------------------------------------------------------------
package sage_pkg;

  localparam int EXP_W = 24;
  localparam int DIV_W = 25;
  localparam int DVS_W = 9;

  localparam logic [15:0] SAT_LEVEL      = 16'hE665;
  localparam logic [15:0] BRIGHT_REF     = 16'hFFEE;
  localparam logic [15:0] FULL_SCALE     = 16'hFFFF;
  localparam logic [23:0] START_EXPOSURE = 24'd65520;
  localparam logic [23:0] EXP_ALL_ONES   = 24'hFFFFFF;
  localparam logic [4:0]  START_MARGIN   = 5'd18;
  localparam logic [7:0]  ATIME_LAST     = 8'hFF;

  // reciprocals: x/20 = ((x>>2)*RECIP_5)>>21, x/360 = ((x>>3)*RECIP_45)>>28
  localparam logic [18:0] RECIP_5        = 19'd419431;
  localparam logic [22:0] RECIP_45       = 23'd5965233;

  localparam logic [1:0] STAT_MEASURE    = 2'd0;
  localparam logic [1:0] STAT_DONE       = 2'd1;
  localparam logic [1:0] STAT_DONE_LIMIT = 2'd2;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic       restart;
    logic       fold;
    logic       gain_dn;
    logic       gain_up;
    logic       set_limit;
    logic       set_expect;
    logic       margin_dn;
    logic       take_trial;
    logic       set_trial;
    logic       finish;
    logic       reuse;
    logic       div_go;
    logic       brk_save;
    logic       quo_save;
    logic       fit_init;
    logic       tint_save;
    logic       step_save;
    logic       mul;
    logic       fit_next;
    logic       fail_set;
    logic       load_out;
  } sage_cmd_t;

  typedef struct packed {
    logic over_sat;
    logic min_zero;
    logic gain_zero;
    logic gain_top;
    logic bright;
    logic margin_zero;
    logic bracket_neg;
    logic trial_over;
    logic div_busy;
    logic match;
    logic a_last;
  } sage_sts_t;

  // channel index modulo six, by repeated subtraction
  function automatic logic [2:0] mod6(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= 5'd6) r = r - 5'd6;
    end
    return r[2:0];
  endfunction

endpackage

[src/sage_if.sv]
// ----------------------------------------------------------------------------
// sage interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface sage_samp_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [4:0]  channel;
  logic [15:0] count;
  logic        last;
  modport source(output valid, opcode, channel, count, last, input ready);
  modport sink(input valid, opcode, channel, count, last, output ready);
endinterface

interface sage_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  gain_code;
  logic [7:0]  step_repeats;
  logic [15:0] step_length;
  logic [1:0]  status;
  logic        fit_failed;
  modport source(output valid, gain_code, step_repeats, step_length, status, fit_failed,
                 input ready);
  modport sink(input valid, gain_code, step_repeats, step_length, status, fit_failed,
               output ready);
endinterface

interface sage_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[src/sage_div.sv]
// ----------------------------------------------------------------------------
// sage_div: serial restoring divider
// One quotient bit per cycle; operands latched on go.
// ----------------------------------------------------------------------------
module sage_div #(
  parameter int DW = 25,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW);

  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem, quotient[DW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      cnt      <= CW'(DW - 1);
    end else if (busy) begin
      rem      <= ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      quotient <= {quotient[DW-2:0], ge};
      cnt      <= cnt - 1'b1;
    end
  end
endmodule

[src/sage_dp.sv]
// ----------------------------------------------------------------------------
// sage_dp: datapath
// Search registers, frame extremes, ATIME/ASTEP fit arithmetic and result register.
// ----------------------------------------------------------------------------
module sage_dp #(
  parameter int CHANNELS = 18,
  parameter int GAIN_TOP = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  sage_pkg::sage_cmd_t cmd,
  output sage_pkg::sage_sts_t sts,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_data,
  input  logic [4:0]          channel,
  input  logic [15:0]         count,
  output logic [3:0]          gain_code,
  output logic [7:0]          step_repeats,
  output logic [15:0]         step_length,
  output logic [1:0]          status,
  output logic                fit_failed
);
  import sage_pkg::*;

  logic [23:0] max_exposure;
  logic [3:0]  gain;
  logic [15:0] frame_max;
  logic [15:0] frame_min;
  logic [23:0] exposure;
  logic [23:0] trial_exposure;
  logic [4:0]  margin_steps;
  logic [15:0] expected_counts;
  logic        gain_limit_hit;

  logic [23:0]      fit_e;
  logic [1:0]       fit_status;
  logic [15:0]      tint;
  logic [7:0]       atime;
  logic [15:0]      step;
  logic [DIV_W-1:0] prod;
  logic             fail;
  logic [18:0]      brk;
  logic [15:0]      plan_quo;

  logic [DIV_W-1:0] div_a;
  logic [DVS_W-1:0] div_b;
  logic             div_busy;
  logic [DIV_W-1:0] quo;

  logic [21:0]      pos_part;
  logic [21:0]      neg_part;
  logic [21:0]      bracket;
  logic [21:0]      bright_lhs;
  logic [21:0]      bright_rhs;
  logic [37:0]      brk_mul;
  logic [44:0]      tint_mul;
  logic [44:0]      prod_mul;
  logic [16:0]      tint_ms;
  logic [16:0]      prod_ms;
  logic [DIV_W-1:0] trial_sum;
  logic [15:0]      step_sat;
  logic             fold_ok;

  assign fold_ok    = (32'(channel) < CHANNELS) && (mod6(channel) != 3'd5);
  assign pos_part   = 22'(margin_steps) * 22'(FULL_SCALE);
  assign neg_part   = 22'(expected_counts) * 22'd20;
  assign bracket    = pos_part - neg_part;
  assign bright_lhs = 22'(frame_max) * 22'd20;
  assign bright_rhs = 22'(margin_steps) * 22'(BRIGHT_REF);
  // bracket/20 from the registered quarter bracket
  assign brk_mul    = 38'(brk) * 38'(RECIP_5);
  // exposure and step product in whole milliseconds
  assign tint_mul   = 45'(fit_e[23:3]) * 45'(RECIP_45);
  assign prod_mul   = 45'(prod[DIV_W-1:3]) * 45'(RECIP_45);
  assign tint_ms    = {1'b0, tint};
  assign prod_ms    = {1'b0, prod_mul[43:28]};
  assign trial_sum  = DIV_W'(exposure) + DIV_W'(plan_quo);
  assign step_sat   = (quo > DIV_W'(FULL_SCALE)) ? FULL_SCALE : quo[15:0];
  assign div_a      = DIV_W'(fit_e);
  assign div_b      = {1'b0, atime} + 9'd1;

  sage_div #(.DW(DIV_W), .VW(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    sts.over_sat    = frame_max > SAT_LEVEL;
    sts.min_zero    = frame_min == 16'd0;
    sts.gain_zero   = gain == 4'd0;
    sts.gain_top    = gain >= 4'(GAIN_TOP);
    sts.bright      = bright_lhs >= bright_rhs;
    sts.margin_zero = margin_steps == 5'd0;
    sts.bracket_neg = neg_part > pos_part;
    sts.trial_over  = trial_sum > DIV_W'(max_exposure);
    sts.div_busy    = div_busy;
    sts.match       = (prod_ms <= tint_ms + 17'd1) && (tint_ms <= prod_ms + 17'd1);
    sts.a_last      = atime == ATIME_LAST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_exposure    <= EXP_ALL_ONES;
      gain            <= 4'(GAIN_TOP);
      frame_max       <= '0;
      frame_min       <= '1;
      exposure        <= START_EXPOSURE;
      trial_exposure  <= '0;
      margin_steps    <= START_MARGIN;
      expected_counts <= '0;
      gain_limit_hit  <= 1'b0;
    end else begin
      if (cfg_we) max_exposure <= cfg_data;
      if (cmd.restart) begin
        gain            <= 4'(GAIN_TOP);
        exposure        <= START_EXPOSURE;
        trial_exposure  <= '0;
        margin_steps    <= START_MARGIN;
        expected_counts <= '0;
        gain_limit_hit  <= 1'b0;
      end
      if (cmd.gain_dn) gain <= gain - 1'b1;
      if (cmd.gain_up) gain <= gain + 1'b1;
      if (cmd.restart || cmd.gain_dn || cmd.gain_up || cmd.set_trial) begin
        frame_max <= '0;
        frame_min <= '1;
      end else if (cmd.fold && fold_ok) begin
        if (count > frame_max) frame_max <= count;
        if (count < frame_min) frame_min <= count;
      end
      if (cmd.set_limit) gain_limit_hit <= 1'b1;
      if (cmd.set_expect) expected_counts <= frame_max;
      if (cmd.margin_dn) margin_steps <= margin_steps - 1'b1;
      if (cmd.take_trial) exposure <= trial_exposure;
      if (cmd.set_trial) trial_exposure <= trial_sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      fit_e      <= START_EXPOSURE;
      fit_status <= STAT_MEASURE;
    end else if (cmd.reuse) begin
      fit_e      <= exposure;
      fit_status <= STAT_MEASURE;
    end else if (cmd.set_trial) begin
      fit_e      <= trial_sum[23:0];
      fit_status <= STAT_MEASURE;
    end else if (cmd.finish) begin
      fit_e      <= exposure;
      fit_status <= gain_limit_hit ? STAT_DONE_LIMIT : STAT_DONE;
    end
    if (cmd.fit_init) begin
      atime <= '0;
      fail  <= 1'b0;
    end
    if (cmd.brk_save) brk <= bracket[20:2];
    if (cmd.quo_save) plan_quo <= brk_mul[36:21];
    if (cmd.fit_next) atime <= atime + 1'b1;
    if (cmd.tint_save) tint <= tint_mul[43:28];
    if (cmd.step_save) step <= step_sat;
    if (cmd.mul) prod <= DIV_W'(({17'd0, atime} + 25'd1) * ({9'd0, step} + 25'd1));
    if (cmd.fail_set) fail <= 1'b1;
    if (cmd.load_out) begin
      gain_code    <= gain;
      step_repeats <= atime;
      step_length  <= step;
      status       <= fit_status;
      fit_failed   <= fail;
    end
  end

  a_gain_range: assert property (@(posedge clk) disable iff (rst) gain <= 4'(GAIN_TOP))
    else $error("gain above its top setting");
  a_margin_range: assert property (@(posedge clk) disable iff (rst)
      margin_steps <= START_MARGIN)
    else $error("margin above its start value");
endmodule

[src/sage_ctrl.sv]
// ----------------------------------------------------------------------------
// sage_ctrl: controller
// Search phase and sequencing of frame decisions, planning and ATIME fit.
// ----------------------------------------------------------------------------
module sage_ctrl (
  input  logic                clk,
  input  logic                rst,
  output sage_pkg::sage_cmd_t cmd,
  input  sage_pkg::sage_sts_t sts,
  input  logic                samp_valid,
  input  logic                samp_opcode,
  input  logic                samp_last,
  output logic                samp_ready,
  output logic                res_valid,
  input  logic                res_ready
);
  import sage_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_GAIN  = 2'd1;
  localparam logic [1:0] PH_TRIAL = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [3:0] S_WAIT    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_PLAN    = 4'd2;
  localparam logic [3:0] S_PLANQ   = 4'd3;
  localparam logic [3:0] S_PLANCHK = 4'd4;
  localparam logic [3:0] S_FIN     = 4'd5;
  localparam logic [3:0] S_FITGO   = 4'd6;
  localparam logic [3:0] S_SGO     = 4'd7;
  localparam logic [3:0] S_SDIV    = 4'd8;
  localparam logic [3:0] S_MUL     = 4'd9;
  localparam logic [3:0] S_CHK     = 4'd10;
  localparam logic [3:0] S_LOAD    = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic       measuring;
  logic       can_load;

  assign samp_ready = state == S_WAIT;
  assign measuring  = phase == PH_GAIN || phase == PH_TRIAL;
  assign can_load   = !res_valid || res_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_WAIT: begin
        if (samp_valid) begin
          if (samp_opcode == OP_START) begin
            cmd.restart = 1'b1;
            phase_next  = PH_GAIN;
            state_next  = S_FITGO;
          end else if (measuring) begin
            cmd.fold = 1'b1;
            if (samp_last) state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (phase == PH_GAIN) begin
          if (sts.over_sat && !sts.gain_zero) begin
            cmd.gain_dn = 1'b1;
            cmd.reuse   = 1'b1;
            state_next  = S_FITGO;
          end else if (!sts.over_sat && sts.min_zero && !sts.gain_top) begin
            cmd.gain_up = 1'b1;
            cmd.reuse   = 1'b1;
            state_next  = S_FITGO;
          end else begin
            // limit reached or frame in range: hand over to the exposure trial
            cmd.set_limit  = sts.over_sat || sts.min_zero;
            cmd.set_expect = 1'b1;
            state_next     = S_PLAN;
          end
        end else if (sts.bright) begin
          if (sts.margin_zero) begin
            state_next = S_FIN;
          end else begin
            cmd.margin_dn = 1'b1;
            state_next    = S_PLAN;
          end
        end else begin
          cmd.take_trial = 1'b1;
          state_next     = S_FIN;
        end
      end
      S_PLAN: begin
        if (sts.bracket_neg) begin
          state_next = S_FIN;
        end else begin
          cmd.brk_save = 1'b1;
          state_next   = S_PLANQ;
        end
      end
      S_PLANQ: begin
        cmd.quo_save = 1'b1;
        state_next   = S_PLANCHK;
      end
      S_PLANCHK: begin
        if (sts.trial_over) begin
          state_next = S_FIN;
        end else begin
          cmd.set_trial = 1'b1;
          phase_next    = PH_TRIAL;
          state_next    = S_FITGO;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        phase_next = PH_DONE;
        state_next = S_FITGO;
      end
      S_FITGO: begin
        cmd.fit_init  = 1'b1;
        cmd.tint_save = 1'b1;
        state_next    = S_SGO;
      end
      S_SGO: begin
        cmd.div_go = 1'b1;
        state_next = S_SDIV;
      end
      S_SDIV: begin
        if (!sts.div_busy) begin
          cmd.step_save = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.match) begin
          state_next = S_LOAD;
        end else if (sts.a_last) begin
          cmd.fail_set = 1'b1;
          state_next   = S_LOAD;
        end else begin
          cmd.fit_next = 1'b1;
          state_next   = S_SGO;
        end
      end
      S_LOAD: begin
        if (can_load) begin
          cmd.load_out = 1'b1;
          state_next   = S_WAIT;
        end
      end
      default: state_next = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      phase     <= PH_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.load_out) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  a_div_idle_on_go: assert property (@(posedge clk) disable iff (rst)
      cmd.div_go |-> !sts.div_busy)
    else $error("divider started while busy");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
      cmd.load_out |=> res_valid)
    else $error("loaded result not presented");
  a_check_settled: assert property (@(posedge clk) disable iff (rst)
      state == S_CHK |-> !sts.div_busy && phase != PH_IDLE)
    else $error("fit check with divider busy or search idle");
endmodule

[src/spectral_auto_gain_exposure_unit.sv]
// ----------------------------------------------------------------------------
// spectral_auto_gain_exposure_unit: auto gain and exposure controller
// Searches gain and exposure frame by frame and reports ATIME/ASTEP settings.
// ----------------------------------------------------------------------------
//  channel | dir | beat carries
//  --------+-----+-------------------------------------------------------------
//  samp    | in  | opcode, channel, count, last (start or one channel sample)
//  res     | out | gain_code, step_repeats, step_length, status, fit_failed
//  cfg     | in  | data: max_exposure, 1/360 ms units (always ready)
//
//  Samples that do not end a frame are folded in and can be taken back to back.
//  A start beat runs the ATIME fit: one serial division by ATIME+1 for each
//  ATIME tried, from 0 up to 255, until one fits. A frame end adds a decision
//  step, S_PLAN, S_PLANQ and S_PLANCHK for a trial plan, and S_FIN to finish.
//  rst is synchronous; it clears the search to idle with gain 12, 182 ms.
//  A finished result waits in the output register while the next beat is
//  taken; a further result holds the controller until res is drained.
// ----------------------------------------------------------------------------
module spectral_auto_gain_exposure_unit #(
  parameter int CHANNELS = 18,
  parameter int GAIN_TOP = 12
) (
  input logic        clk,
  input logic        rst,
  sage_samp_if.sink  samp,
  sage_res_if.source res,
  sage_cfg_if.sink   cfg
);
  import sage_pkg::*;

  sage_cmd_t cmd;
  sage_sts_t sts;

  // configuration beats are always taken and land at once
  assign cfg.ready = 1'b1;

  // controller: phase of the search and step sequencing
  sage_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .samp_valid  (samp.valid),
    .samp_opcode (samp.opcode),
    .samp_last   (samp.last),
    .samp_ready  (samp.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready)
  );

  // datapath: frame extremes, search registers, divider and result register
  sage_dp #(.CHANNELS(CHANNELS), .GAIN_TOP(GAIN_TOP)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.data),
    .channel      (samp.channel),
    .count        (samp.count),
    .gain_code    (res.gain_code),
    .step_repeats (res.step_repeats),
    .step_length  (res.step_length),
    .status       (res.status),
    .fit_failed   (res.fit_failed)
  );
endmodule

[dv/sage_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sage_checker: result predictor and scoreboard
// Watches the sample, result and configuration channels and predicts every
// result of the gain and exposure search. Each result beat is compared, field
// by field, with the oldest prediction. Mismatches are counted.
// ----------------------------------------------------------------------------
module sage_checker #(
  parameter int CHANNELS = 18,
  parameter int GAIN_TOP = 12
) (
  input  logic   clk,
  input  logic   rst,
  sage_samp_if   samp,
  sage_res_if    res,
  sage_cfg_if    cfg,
  output int     errors,
  output int     pending,
  output int     results_seen
);
  import sage_pkg::*;

  typedef enum logic [2:0] {SRCH_IDLE, SRCH_GAIN, SRCH_TRIAL, SRCH_DONE} search_t;

  typedef struct packed {
    logic [3:0]  gain_code;
    logic [7:0]  step_repeats;
    logic [15:0] step_length;
    logic [1:0]  status;
    logic        fit_failed;
  } setting_t;

  setting_t    settings_q[$];
  logic [23:0] exp_limit;
  search_t     srch;
  logic [3:0]  gain;
  logic [15:0] fmax, fmin;
  logic [23:0] exposure, trial_exp;
  logic [4:0]  margin;
  logic [15:0] expect_cnt;
  logic        limit_hit;

  assign pending = settings_q.size();

  // search the ATIME/ASTEP pair for one exposure
  function automatic setting_t fit_setting(input logic [23:0] e, input logic [1:0] st);
    setting_t         r;
    longint unsigned  tint, s, prod, d, a;
    logic             found;
    tint  = e / 360;
    found = 1'b0;
    s     = 0;
    for (a = 0; a < 256 && !found; a++) begin
      s = e / (a + 1);
      if (s > 65535) s = 65535;
      prod = (a + 1) * (s + 1) / 360;
      d = (prod > tint) ? prod - tint : tint - prod;
      if (d <= 1) begin
        found = 1'b1;
        r.step_repeats = a[7:0];
      end
    end
    if (!found) begin
      r.step_repeats = ATIME_LAST;
      s = e / 256;
      if (s > 65535) s = 65535;
    end
    r.gain_code   = gain;
    r.step_length = s[15:0];
    r.status      = st;
    r.fit_failed  = !found;
    return r;
  endfunction

  function automatic void clear_frame();
    fmax = '0;
    fmin = 16'hFFFF;
  endfunction

  function automatic void finish_search();
    srch = SRCH_DONE;
    settings_q.push_back(fit_setting(exposure, limit_hit ? STAT_DONE_LIMIT : STAT_DONE));
  endfunction

  function automatic void plan_trial();
    longint          bracket;
    longint unsigned t;
    bracket = longint'(margin) * 65535 - 20 * longint'(expect_cnt);
    if (bracket < 0) begin
      finish_search();
      return;
    end
    t = exposure + bracket / 20;
    if (t > exp_limit) begin
      finish_search();
      return;
    end
    trial_exp = t[23:0];
    srch      = SRCH_TRIAL;
    clear_frame();
    settings_q.push_back(fit_setting(trial_exp, STAT_MEASURE));
  endfunction

  function automatic void take_beat(input logic op, input logic [4:0] ch,
                                    input logic [15:0] cnt, input logic lst);
    if (op == OP_START) begin
      gain       = 4'(GAIN_TOP);
      exposure   = START_EXPOSURE;
      trial_exp  = '0;
      margin     = START_MARGIN;
      expect_cnt = '0;
      limit_hit  = 1'b0;
      clear_frame();
      srch = SRCH_GAIN;
      settings_q.push_back(fit_setting(exposure, STAT_MEASURE));
      return;
    end
    if (srch != SRCH_GAIN && srch != SRCH_TRIAL) return;
    if (ch < CHANNELS && (ch % 6) != 5) begin
      if (cnt > fmax) fmax = cnt;
      if (cnt < fmin) fmin = cnt;
    end
    if (!lst) return;
    if (srch == SRCH_GAIN) begin
      if (fmax > SAT_LEVEL) begin
        if (gain == 0) limit_hit = 1'b1;
        else begin
          gain = gain - 4'd1;
          clear_frame();
          settings_q.push_back(fit_setting(exposure, STAT_MEASURE));
          return;
        end
      end else if (fmin == 0) begin
        if (gain >= GAIN_TOP) limit_hit = 1'b1;
        else begin
          gain = gain + 4'd1;
          clear_frame();
          settings_q.push_back(fit_setting(exposure, STAT_MEASURE));
          return;
        end
      end
      expect_cnt = fmax;
      plan_trial();
    end else begin
      if (20 * longint'(fmax) >= longint'(margin) * BRIGHT_REF) begin
        if (margin == 0) finish_search();
        else begin
          margin = margin - 5'd1;
          plan_trial();
        end
      end else begin
        exposure = trial_exp;
        finish_search();
      end
    end
  endfunction

  always @(posedge clk) begin
    setting_t want, got;
    if (rst) begin
      exp_limit  = EXP_ALL_ONES;
      srch       = SRCH_IDLE;
      gain       = 4'(GAIN_TOP);
      exposure   = START_EXPOSURE;
      trial_exp  = '0;
      margin     = START_MARGIN;
      expect_cnt = '0;
      limit_hit  = 1'b0;
      clear_frame();
      settings_q.delete();
      errors       = 0;
      results_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) exp_limit = cfg.data;
      if (samp.valid && samp.ready)
        take_beat(samp.opcode, samp.channel, samp.count, samp.last);
      if (res.valid && res.ready) begin
        got = '{res.gain_code, res.step_repeats, res.step_length, res.status,
                res.fit_failed};
        results_seen++;
        if (settings_q.size() == 0) begin
          $error("unexpected result beat: gain_code=%0d status=%0d",
                 got.gain_code, got.status);
          errors++;
        end else begin
          want = settings_q.pop_front();
          if (got.gain_code != want.gain_code) begin
            $error("gain_code: expected %0d, got %0d", want.gain_code, got.gain_code);
            errors++;
          end
          if (got.step_repeats != want.step_repeats) begin
            $error("step_repeats: expected %0d, got %0d",
                   want.step_repeats, got.step_repeats);
            errors++;
          end
          if (got.step_length != want.step_length) begin
            $error("step_length: expected %0d, got %0d",
                   want.step_length, got.step_length);
            errors++;
          end
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.fit_failed != want.fit_failed) begin
            $error("fit_failed: expected %0d, got %0d", want.fit_failed, got.fit_failed);
            errors++;
          end
        end
      end
    end
  end

endmodule

[dv/spectral_auto_gain_exposure_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_auto_gain_exposure_unit_test: stimulus and verdict
// Drives start beats and sensor frames through the gain and exposure search
// under several exposure limits, with random gaps on both channels. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module spectral_auto_gain_exposure_unit_test;
  import sage_pkg::*;

  localparam int CHANNELS   = 18;
  localparam int GAIN_TOP   = 12;
  localparam int PHASE_BEATS = 210;

  logic clk;
  logic rst;
  int   errors, pending, results_seen;
  int   beats_sent;
  int   phase_end;
  bit   calm;          // suppress idling on both sides for a stretch

  sage_samp_if samp();
  sage_res_if  res();
  sage_cfg_if  cfg();

  spectral_auto_gain_exposure_unit #(.CHANNELS(CHANNELS), .GAIN_TOP(GAIN_TOP)) u_top (
    .clk (clk),
    .rst (rst),
    .samp(samp),
    .res (res),
    .cfg (cfg)
  );

  sage_checker #(.CHANNELS(CHANNELS), .GAIN_TOP(GAIN_TOP)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .samp        (samp),
    .res         (res),
    .cfg         (cfg),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #500_000_000;
    $display("spectral_auto_gain_exposure_unit_test: errors");
    $finish;
  end

  // Mostly no gap, some short ones, the odd long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result sink: toggle ready at the falling edge, long stalls now and then.
  initial begin
    int hold;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      hold = pick_gap();
      if (hold == 0) res.ready = 1'b1;
      else begin
        res.ready = 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  // Send one beat; hold valid across back-to-back beats, drop it for a gap.
  task automatic send_beat(input logic op, input logic [4:0] ch,
                           input logic [15:0] cnt, input logic lst);
    int gap;
    samp.valid   = 1'b1;
    samp.opcode  = op;
    samp.channel = ch;
    samp.count   = cnt;
    samp.last    = lst;
    do @(posedge clk); while (!samp.ready);
    beats_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      samp.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Let the search drain before touching the limit register.
  task automatic write_limit(input logic [23:0] value);
    samp.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.data  = value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Pick one channel count to steer the search the given way.
  function automatic logic [15:0] frame_count(input int kind);
    case (kind)
      0: return 16'($urandom_range(16'hE666, 16'hFFFF));   // saturating
      1: return 16'd0;                                     // dark channel
      2: return 16'($urandom_range(16'hD000, 16'hFFFF));   // too bright for a trial
      3: return 16'($urandom_range(1, 16'h3000));          // dim
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // One well-formed frame: channels in order, last on the final one.
  task automatic send_frame(input int kind);
    int hot;
    hot = $urandom_range(0, CHANNELS - 1);
    for (int c = 0; c < CHANNELS; c++) begin
      if (c == hot || kind == 2 || kind == 3)
        send_beat(OP_SAMPLE, c[4:0], frame_count(kind), c == CHANNELS - 1);
      else
        send_beat(OP_SAMPLE, c[4:0], 16'($urandom_range(1, 16'hE000)),
                  c == CHANNELS - 1);
    end
  endtask

  // Broken or short frames: any channel, early last marks, stray starts.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(OP_START, 5'($urandom), 16'($urandom), 1'($urandom));
      else
        send_beat(OP_SAMPLE, 5'($urandom), 16'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  // One search: start, then frames steered mostly towards completion.
  task automatic send_search();
    int frames;
    send_beat(OP_START, 5'($urandom), 16'($urandom), 1'($urandom));
    frames = $urandom_range(1, 24);
    repeat (frames) begin
      if (beats_sent >= phase_end) break;
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_frame($urandom_range(0, 4));
    end
  endtask

  initial begin
    logic [23:0] limits[5];
    samp.valid = 1'b0;
    samp.opcode = OP_SAMPLE;
    samp.channel = '0;
    samp.count = '0;
    samp.last = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    beats_sent = 0;
    phase_end = 0;
    calm = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening: ignored sample while idle, skipped and stray channels,
    // empty frame, bright trials, a finished search, gain down, up and limit.
    send_beat(OP_SAMPLE, 5'd0, 16'd0, 1'b1);
    send_beat(OP_START, 5'd31, 16'hFFFF, 1'b1);
    send_beat(OP_SAMPLE, 5'd5, 16'd0, 1'b0);
    send_beat(OP_SAMPLE, 5'd31, 16'd0, 1'b1);
    send_beat(OP_SAMPLE, 5'd0, 16'hFFFF, 1'b1);
    send_beat(OP_SAMPLE, 5'd17, 16'd0, 1'b0);
    send_beat(OP_SAMPLE, 5'd16, 16'hFFFF, 1'b1);
    send_beat(OP_SAMPLE, 5'd0, 16'd0, 1'b1);
    send_beat(OP_SAMPLE, 5'd0, 16'd0, 1'b1);
    send_beat(OP_START, 5'd0, 16'd0, 1'b0);
    send_beat(OP_SAMPLE, 5'd0, 16'hFFFF, 1'b1);
    send_beat(OP_SAMPLE, 5'd1, 16'd0, 1'b1);
    send_beat(OP_SAMPLE, 5'd2, 16'd0, 1'b1);
    send_beat(OP_SAMPLE, 5'd3, 16'hE665, 1'b1);
    send_beat(OP_SAMPLE, 5'd4, 16'd1, 1'b1);
    send_beat(OP_START, 5'd0, 16'd0, 1'b0);
    repeat (13) send_beat(OP_SAMPLE, 5'd0, 16'hFFFF, 1'b1);

    // Random part under several exposure limits, extremes among them.
    limits[0] = 24'd0;
    limits[1] = 24'($urandom_range(65520, 130000));
    limits[2] = 24'd65521;
    limits[3] = 24'($urandom);
    limits[4] = EXP_ALL_ONES;
    foreach (limits[i]) begin
      write_limit(limits[i]);
      calm = (i == 2);
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        else send_search();
      end
      calm = 1'b0;
    end

    samp.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Sent %0d sample beats over %0d exposure limits; checked %0d results.",
             beats_sent, 5, results_seen);
    if (errors == 0)
      $display("spectral_auto_gain_exposure_unit_test: clean");
    else
      $display("spectral_auto_gain_exposure_unit_test: errors");
    $finish;
  end

endmodule

[files.f]
src/sage_pkg.sv
src/sage_if.sv
src/sage_div.sv
src/sage_dp.sv
src/sage_ctrl.sv
src/spectral_auto_gain_exposure_unit.sv
dv/sage_checker.sv
dv/spectral_auto_gain_exposure_unit_test.sv
